FILE: hdl/float_power_by_squaring_core_defines.svh
// Assertion macros for the float power-by-squaring core.
`ifndef FLOAT_POWER_BY_SQUARING_CORE_DEFINES_SVH
`define FLOAT_POWER_BY_SQUARING_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Check that prop holds at every clock edge outside reset.
`define FPSQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("fpsq assertion failed");
// Check that cond never holds outside reset.
`define FPSQ_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("fpsq forbidden condition seen");
`else
`define FPSQ_ASSERT(lbl, clk, rst_n, prop)
`define FPSQ_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

FILE: hdl/fpsq_pkg.sv
// Shared types, constants and the rounding function of the power core.
`default_nettype none

package fpsq_pkg;

    // Working exponent width: biased exponent with headroom for sums and underflow.
    localparam int EXP_W = 14;
    // Rounder significand: 53 significant bits, round bit, sticky bit.
    localparam int M_W = 55;

    localparam logic [62:0] NEAR_ZERO_MAG = 63'h3E7A_D7F2_9ABC_AF48;
    localparam logic [63:0] ONE_BITS      = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] QNAN_BIT      = 64'h0008_0000_0000_0000;
    localparam logic [63:0] DEFAULT_NAN   = 64'hFFF8_0000_0000_0000;
    localparam logic [62:0] INF_MAG       = 63'h7FF0_0000_0000_0000;

    // Result register sources.
    localparam logic [2:0] RES_ZERO  = 3'd0;
    localparam logic [2:0] RES_ONE   = 3'd1;
    localparam logic [2:0] RES_ACC   = 3'd2;
    localparam logic [2:0] RES_RECIP = 3'd3;
    localparam logic [2:0] RES_DIV   = 3'd4;

    typedef struct packed {
        logic       load;
        logic       shift;
        logic       sq_start;
        logic       mx_start;
        logic       acc_load;
        logic       div_start;
        logic       res_we;
        logic [2:0] res_sel;
    } t_cmd;

    typedef struct packed {
        logic near_zero;
        logic exp_zero;
        logic mag_top;
        logic cnt_zero;
        logic neg;
        logic recip_special;
        logic mul_done;
        logic div_done;
    } t_sts;

    // Round to nearest even; value = m x 2^(e-1023), leading one at m[54] unless e < 1.
    function automatic logic [63:0] fp_round(
        input logic                    sign,
        input logic signed [EXP_W-1:0] e,
        input logic [M_W-1:0]          m
    );
        logic signed [EXP_W-1:0] sh_full;
        logic [5:0]              sh;
        logic [63:0]             v;
        logic [63:0]             shv;
        logic [63:0]             mask;
        logic                    lost;
        logic [52:0]             sig;
        logic                    rb;
        logic                    sb;
        logic                    inc;
        logic [53:0]             sum;
        logic signed [EXP_W-1:0] ef;
        logic [63:0]             res;
        sh_full = 14'sd1 - e;
        if (e >= 14'sd1) begin
            sh = 6'd0;
        end else if (sh_full > 14'sd63) begin
            sh = 6'd63;
        end else begin
            sh = sh_full[5:0];
        end
        v    = {m[M_W-1:1], 10'b0};
        shv  = v >> sh;
        mask = (64'd1 << sh) - 64'd1;
        lost = |(v & mask);
        sig  = shv[63:11];
        rb   = shv[10];
        sb   = m[0] | (|shv[9:0]) | lost;
        inc  = rb & (sb | sig[0]);
        sum  = {1'b0, sig} + {53'b0, inc};
        if (e >= 14'sd1) begin
            ef = e + {{(EXP_W-1){1'b0}}, sum[53]};
            if (ef >= 14'sd2047) begin
                res = {sign, INF_MAG};
            end else begin
                res = {sign, ef[10:0], (sum[53] ? sum[52:1] : sum[51:0])};
            end
        end else begin
            res = {sign, 10'b0, sum[52], sum[51:0]};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/fpsq_mul.sv
// Multi-cycle double multiplier: four 27x27 partial products, normalize, round.
`default_nettype none

module fpsq_mul (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_a,
    input  wire logic [63:0] i_b,
    output logic             o_done,
    output logic [63:0]      o_res
);
    import fpsq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PP   = 2'd1;
    localparam logic [1:0] S_NORM = 2'd2;
    localparam logic [1:0] S_RND  = 2'd3;

    logic [1:0]              r_state, n_state;
    logic [1:0]              r_k;
    logic [52:0]             r_ma, r_mb;
    logic signed [EXP_W-1:0] r_e;
    logic                    r_sign;
    logic [105:0]            r_p;
    logic [M_W-1:0]          r_m;
    logic [63:0]             r_res;
    logic                    r_done;

    logic [10:0] a_exp, b_exp, a_ee, b_ee;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, special;
    logic [63:0] spec_res;
    logic [26:0] a_part, b_part;
    logic [53:0] pp;
    logic [5:0]  pp_sh;

    always_comb begin
        a_exp  = i_a[62:52];
        b_exp  = i_b[62:52];
        a_nan  = (a_exp == 11'h7FF) && (i_a[51:0] != 52'd0);
        b_nan  = (b_exp == 11'h7FF) && (i_b[51:0] != 52'd0);
        a_inf  = (a_exp == 11'h7FF) && (i_a[51:0] == 52'd0);
        b_inf  = (b_exp == 11'h7FF) && (i_b[51:0] == 52'd0);
        a_zero = (i_a[62:0] == 63'd0);
        b_zero = (i_b[62:0] == 63'd0);
        a_ee   = (a_exp == 11'd0) ? 11'd1 : a_exp;
        b_ee   = (b_exp == 11'd0) ? 11'd1 : b_exp;
        special = a_nan | b_nan | a_inf | b_inf | a_zero | b_zero;
        priority if (a_nan) begin
            spec_res = i_a | QNAN_BIT;
        end else if (b_nan) begin
            spec_res = i_b | QNAN_BIT;
        end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
            spec_res = DEFAULT_NAN;
        end else if (a_inf || b_inf) begin
            spec_res = {i_a[63] ^ i_b[63], INF_MAG};
        end else begin
            spec_res = {i_a[63] ^ i_b[63], 63'd0};
        end
    end

    always_comb begin
        a_part = r_k[1] ? {1'b0, r_ma[52:27]} : r_ma[26:0];
        b_part = r_k[0] ? {1'b0, r_mb[52:27]} : r_mb[26:0];
        pp     = a_part * b_part;
        pp_sh  = (r_k[1] ? 6'd27 : 6'd0) + (r_k[0] ? 6'd27 : 6'd0);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_start && !special) n_state = S_PP;
            S_PP:   if (r_k == 2'd3) n_state = S_NORM;
            S_NORM: if (r_p[105] || r_p[104]) n_state = S_RND;
            S_RND:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= ((r_state == S_IDLE) && i_start && special) || (r_state == S_RND);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    r_res  <= spec_res;
                    r_ma   <= {a_exp != 11'd0, i_a[51:0]};
                    r_mb   <= {b_exp != 11'd0, i_b[51:0]};
                    r_sign <= i_a[63] ^ i_b[63];
                    r_e    <= $signed({3'b0, a_ee}) + $signed({3'b0, b_ee}) - 14'sd1023;
                    r_p    <= 106'd0;
                    r_k    <= 2'd0;
                end
            end
            S_PP: begin
                r_p <= r_p + ({52'd0, pp} << pp_sh);
                r_k <= r_k + 2'd1;
            end
            S_NORM: begin
                priority if (r_p[105]) begin
                    r_m <= {r_p[105:53], r_p[52], |r_p[51:0]};
                    r_e <= r_e + 14'sd1;
                end else if (r_p[104]) begin
                    r_m <= {r_p[104:52], r_p[51], |r_p[50:0]};
                end else begin
                    r_p <= r_p << 1;
                    r_e <= r_e - 14'sd1;
                end
            end
            S_RND: r_res <= fp_round(r_sign, r_e, r_m);
            default: r_res <= r_res;
        endcase
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

`default_nettype wire

FILE: hdl/fpsq_div.sv
// Reciprocal unit: restoring division of 1.0 by a finite nonzero double, one bit a cycle.
`default_nettype none

module fpsq_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_p,
    output logic             o_done,
    output logic [63:0]      o_res
);
    import fpsq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_NORM = 2'd1;
    localparam logic [1:0] S_ITER = 2'd2;
    localparam logic [1:0] S_RND  = 2'd3;
    localparam logic [5:0] Q_BITS = 6'd57;

    logic [1:0]              r_state, n_state;
    logic [52:0]             r_d;
    logic signed [EXP_W-1:0] r_e;
    logic                    r_sign;
    logic [53:0]             r_rem;
    logic [56:0]             r_q;
    logic [5:0]              r_cnt;
    logic [63:0]             r_res;
    logic                    r_done;

    logic                    ge;
    logic [53:0]             diff;
    logic signed [EXP_W-1:0] q_e;
    logic [M_W-1:0]          q_m;
    logic                    rem_nz;

    always_comb begin
        ge     = r_rem >= {1'b0, r_d};
        diff   = r_rem - {1'b0, r_d};
        rem_nz = (r_rem != 54'd0);
        if (r_q[56]) begin
            q_e = 14'sd2046 - r_e;
            q_m = {r_q[56:4], r_q[3], (|r_q[2:0]) | rem_nz};
        end else begin
            q_e = 14'sd2045 - r_e;
            q_m = {r_q[55:3], r_q[2], (|r_q[1:0]) | rem_nz};
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_start) n_state = S_NORM;
            S_NORM: if (r_d[52]) n_state = S_ITER;
            S_ITER: if (r_cnt == 6'd1) n_state = S_RND;
            S_RND:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_RND);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    r_d    <= {i_p[62:52] != 11'd0, i_p[51:0]};
                    r_e    <= $signed({3'b0, ((i_p[62:52] == 11'd0) ? 11'd1 : i_p[62:52])});
                    r_sign <= i_p[63];
                end
            end
            S_NORM: begin
                if (r_d[52]) begin
                    r_rem <= 54'd1 << 52;
                    r_q   <= 57'd0;
                    r_cnt <= Q_BITS;
                end else begin
                    r_d <= r_d << 1;
                    r_e <= r_e - 14'sd1;
                end
            end
            S_ITER: begin
                r_q   <= {r_q[55:0], ge};
                r_rem <= ge ? {diff[52:0], 1'b0} : {r_rem[52:0], 1'b0};
                r_cnt <= r_cnt - 6'd1;
            end
            S_RND: r_res <= fp_round(r_sign, q_e, q_m);
            default: r_res <= r_res;
        endcase
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

`default_nettype wire

FILE: hdl/fpsq_dp.sv
// Datapath: operand, accumulator and exponent-bit registers, multiplier, reciprocal unit.
`default_nettype none

module fpsq_dp (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic [63:0]    i_base_bits,
    input  wire logic [31:0]    i_exponent,
    input  wire fpsq_pkg::t_cmd i_cmd,
    output fpsq_pkg::t_sts      o_sts,
    output logic [63:0]         o_result_bits
);
    import fpsq_pkg::*;

    logic [63:0] r_x, r_acc, r_res;
    logic [31:0] r_mag;
    logic [5:0]  r_cnt;
    logic        r_neg;

    logic        mul_done, div_done;
    logic [63:0] mul_res, div_res, recip_res;
    logic        acc_nan, acc_inf, acc_zero;

    fpsq_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sq_start | i_cmd.mx_start),
        .i_a     (r_acc),
        .i_b     (i_cmd.mx_start ? r_x : r_acc),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    fpsq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_p     (r_acc),
        .o_done  (div_done),
        .o_res   (div_res)
    );

    always_comb begin
        acc_zero = (r_acc[62:0] == 63'd0);
        acc_nan  = (r_acc[62:52] == 11'h7FF) && (r_acc[51:0] != 52'd0);
        acc_inf  = (r_acc[62:0] == INF_MAG);
        priority if (acc_zero) begin
            recip_res = {r_acc[63], INF_MAG};
        end else if (acc_nan) begin
            recip_res = r_acc | QNAN_BIT;
        end else begin
            recip_res = {r_acc[63], 63'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x   <= i_base_bits;
            r_acc <= i_base_bits;
            r_neg <= i_exponent[31];
            r_mag <= i_exponent[31] ? (32'd0 - i_exponent) : i_exponent;
            r_cnt <= 6'd32;
        end else begin
            if (i_cmd.shift) begin
                r_mag <= r_mag << 1;
                r_cnt <= r_cnt - 6'd1;
            end
            if (i_cmd.acc_load) begin
                r_acc <= mul_res;
            end
        end
        if (i_cmd.res_we) begin
            unique case (i_cmd.res_sel)
                RES_ZERO:  r_res <= 64'd0;
                RES_ONE:   r_res <= ONE_BITS;
                RES_ACC:   r_res <= r_acc;
                RES_RECIP: r_res <= recip_res;
                RES_DIV:   r_res <= div_res;
                default:   r_res <= r_res;
            endcase
        end
    end

    always_comb begin
        o_sts.near_zero     = (r_x[62:0] < NEAR_ZERO_MAG);
        o_sts.exp_zero      = (r_mag == 32'd0);
        o_sts.mag_top       = r_mag[31];
        o_sts.cnt_zero      = (r_cnt == 6'd0);
        o_sts.neg           = r_neg;
        o_sts.recip_special = acc_zero | acc_nan | acc_inf;
        o_sts.mul_done      = mul_done;
        o_sts.div_done      = div_done;
    end

    assign o_result_bits = r_res;

endmodule

`default_nettype wire

FILE: hdl/fpsq_ctrl.sv
// Controller: sequences the bit scan, square-and-multiply steps and the reciprocal.
`default_nettype none

module fpsq_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_out_stall,
    input  wire fpsq_pkg::t_sts i_sts,
    output fpsq_pkg::t_cmd      o_cmd,
    output logic                o_in_stall,
    output logic                o_out_valid
);
    import fpsq_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_FIND  = 4'd2;
    localparam logic [3:0] S_LOOP  = 4'd3;
    localparam logic [3:0] S_SQW   = 4'd4;
    localparam logic [3:0] S_BIT   = 4'd5;
    localparam logic [3:0] S_MXW   = 4'd6;
    localparam logic [3:0] S_FIN   = 4'd7;
    localparam logic [3:0] S_DIVW  = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                priority if (i_sts.near_zero) begin
                    o_cmd.res_we  = 1'b1;
                    o_cmd.res_sel = RES_ZERO;
                    n_state       = S_OUT;
                end else if (i_sts.exp_zero) begin
                    o_cmd.res_we  = 1'b1;
                    o_cmd.res_sel = RES_ONE;
                    n_state       = S_OUT;
                end else begin
                    n_state = S_FIND;
                end
            end
            S_FIND: begin
                o_cmd.shift = 1'b1;
                if (i_sts.mag_top) n_state = S_LOOP;
            end
            S_LOOP: begin
                if (i_sts.cnt_zero) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.sq_start = 1'b1;
                    n_state        = S_SQW;
                end
            end
            S_SQW: begin
                if (i_sts.mul_done) begin
                    o_cmd.acc_load = 1'b1;
                    n_state        = S_BIT;
                end
            end
            S_BIT: begin
                if (i_sts.mag_top) begin
                    o_cmd.mx_start = 1'b1;
                    n_state        = S_MXW;
                end else begin
                    o_cmd.shift = 1'b1;
                    n_state     = S_LOOP;
                end
            end
            S_MXW: begin
                if (i_sts.mul_done) begin
                    o_cmd.acc_load = 1'b1;
                    o_cmd.shift    = 1'b1;
                    n_state        = S_LOOP;
                end
            end
            S_FIN: begin
                o_cmd.res_we = 1'b1;
                priority if (!i_sts.neg) begin
                    o_cmd.res_sel = RES_ACC;
                    n_state       = S_OUT;
                end else if (i_sts.recip_special) begin
                    o_cmd.res_sel = RES_RECIP;
                    n_state       = S_OUT;
                end else begin
                    o_cmd.res_we    = 1'b0;
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIVW;
                end
            end
            S_DIVW: begin
                if (i_sts.div_done) begin
                    o_cmd.res_we  = 1'b1;
                    o_cmd.res_sel = RES_DIV;
                    n_state       = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_out_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

endmodule

`default_nettype wire

FILE: hdl/float_power_by_squaring_core.sv
// Top level: double base raised to a signed 32-bit power by square-and-multiply.
//
// Input channel: i_in_valid / o_in_stall carry one item (i_base_bits, i_exponent).
// An item is taken at a clock edge with i_in_valid high and o_in_stall low.
// Output channel: o_out_valid / i_out_stall carry o_result_bits, one per item.
// The block works on one item at a time; o_in_stall stays high from acceptance
// until the result has been taken.
// A base near zero or a zero exponent goes from the check state straight to the
// output state, its result written on the way. Otherwise the scan for the leading
// exponent bit shifts the magnitude once per bit down to and including it, and each
// remaining exponent bit costs a squaring plus, when set, a multiply by the base.
// Each product runs on the shared multiplier: issue, four 27x27 partial products,
// normalize with one left shift per extra normalizing step, round, hand-back.
// A negative exponent adds the reciprocal unit, whose divider yields one quotient bit
// per cycle; a zero, infinite or NaN accumulated power gets its reciprocal without it.
// Reset (synchronous, active low) drops any item in flight and returns to idle.
// A stalled result holds on o_result_bits with o_out_valid high until taken.
`default_nettype none

module float_power_by_squaring_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [63:0] i_base_bits,
    input  wire logic signed [31:0] i_exponent,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [63:0]      o_result_bits
);
    import fpsq_pkg::*;

`include "float_power_by_squaring_core_defines.svh"

    t_cmd cmd;
    t_sts sts;

    // Sequence the work.
    fpsq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    // Hold operands, run the multiplier and reciprocal, hold the result.
    fpsq_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_base_bits   (i_base_bits),
        .i_exponent    (i_exponent),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_result_bits (o_result_bits)
    );

    // No item is taken while a result is still on offer.
    `FPSQ_NEVER(a_no_accept_with_result, i_clk, i_rst_n, i_in_valid && !o_in_stall && o_out_valid)
    // Once an item is taken, the input side closes.
    `FPSQ_ASSERT(a_stall_after_accept, i_clk, i_rst_n, (i_in_valid && !o_in_stall) |=> o_in_stall)
    // A taken result is not offered twice.
    `FPSQ_ASSERT(a_result_once, i_clk, i_rst_n, (o_out_valid && !i_out_stall) |=> !o_out_valid)

endmodule

`default_nettype wire

FILE: dv/float_power_by_squaring_core_test.sv
// Testbench for the double power-by-squaring core: directed table plus random items.
`default_nettype none

module float_power_by_squaring_core_test;
    import fpsq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM     = 1880;
    localparam int STALL_LIMIT  = 20000;   // idle cycles with no handshake at all
    localparam int DRAIN_CYCLES = 700;     // beyond the slowest item

    localparam logic [63:0] POS_INF  = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] NEG_INF  = 64'hFFF0_0000_0000_0000;
    localparam logic [63:0] MAX_DBL  = 64'h7FEF_FFFF_FFFF_FFFF;
    localparam logic [63:0] TWO      = 64'h4000_0000_0000_0000;
    localparam logic [63:0] HALF     = 64'h3FE0_0000_0000_0000;
    localparam logic [63:0] NEG_ONE  = 64'hBFF0_0000_0000_0000;
    localparam logic [63:0] NEG_ZERO = 64'h8000_0000_0000_0000;
    localparam logic [63:0] QNAN     = 64'h7FF8_0000_0000_0001;
    localparam logic [63:0] SNAN_NEG = 64'hFFF0_0000_0000_0003;
    localparam logic [31:0] EXP_MIN  = 32'h8000_0000;
    localparam logic [31:0] EXP_MAX  = 32'h7FFF_FFFF;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [63:0] i_base_bits = '0;
    logic signed [31:0] i_exponent = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [63:0] o_result_bits;

    logic [63:0] pending_results[$];
    int          mismatch_count = 0;
    int          idle_cycles = 0;
    bit          quiet_phase = 1'b0;

    typedef struct {
        logic [63:0] base;
        logic [31:0] expo;
        bit          known;      // expected value typed in below
        logic [63:0] result;
    } t_row;

    always #2 i_clk = ~i_clk;

    float_power_by_squaring_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_base_bits  (i_base_bits),
        .i_exponent   (i_exponent),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_result_bits(o_result_bits)
    );

    // Square-and-multiply in host doubles, which round to nearest even per product.
    function automatic logic [63:0] raise_power(logic [63:0] base, logic [31:0] expo);
        real         x;
        real         acc;
        logic [31:0] mag;
        logic [63:0] pb;
        int          top;
        x = $bitstoreal(base);
        // NaN fails both compares, so it falls through like any other base
        if (x > -0.0000001 && x < 0.0000001) return 64'd0;
        if (expo == 32'd0) return ONE_BITS;
        mag = expo[31] ? 32'd0 - expo : expo;   // -2^31 stays 2^31 unsigned
        top = 31;
        while (top > 0 && !mag[top]) top--;
        acc = x;
        for (int i = top - 1; i >= 0; i--) begin
            acc = acc * acc;
            if (mag[i]) acc = acc * x;
        end
        pb = $realtobits(acc);
        if (!expo[31]) return pb;
        // reciprocal of a signed zero is the infinity of that sign
        if (pb[62:0] == 63'd0) return {pb[63], INF_MAG};
        return $realtobits(1.0 / acc);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // Mostly short gaps, a few long ones; none while quiet_phase is set.
    function automatic int gap_len();
        int r;
        if (quiet_phase) return 0;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Offer one item, hold it until taken, and queue its expected result.
    task automatic send_item(input logic [63:0] base, input logic [31:0] expo,
                             input bit known, input logic [63:0] result);
        int g;
        g = gap_len();
        // always move on to a fresh falling edge before driving
        repeat (g + 1) @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_base_bits <= base;
        i_exponent  <= expo;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_results.push_back(known ? result : raise_power(base, expo));
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    function automatic logic [63:0] pick_base();
        logic [63:0] b;
        int          r;
        b = {$urandom, $urandom};
        r = $urandom_range(99);
        // near one: powers stay finite for longer, so rounding gets exercised
        if (r < 45) b[62:52] = 11'h3FE + 11'($urandom_range(1));
        else if (r < 70) b[62:52] = 11'h3F0 + 11'($urandom_range(30));
        else if (r < 78) b[62:52] = $urandom_range(1) ? 11'h7FF : 11'h000;
        else if (r < 84) b[62:0] = NEAR_ZERO_MAG + 63'($urandom_range(4)) - 63'd2;
        else if (r < 88) b[51:0] = 52'd0;
        return b;
    endfunction

    function automatic logic [31:0] pick_exponent();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 32'($signed($urandom_range(128)) - 64);
        if (r < 75) return 32'($signed($urandom_range(4096)) - 2048);
        if (r < 80) return $urandom_range(1) ? EXP_MIN : EXP_MAX;
        if (r < 85) return 32'd0;
        return $urandom;
    endfunction

    // Result side: random back-pressure, check each result against the oldest expectation.
    initial begin
        int g;
        forever begin
            @(negedge i_clk);
            g = gap_len();
            if (g != 0) begin
                i_out_stall <= 1'b1;
                repeat (g) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", o_result_bits, 64'd0);
            end else begin
                if (o_result_bits !== pending_results[0])
                    report_mismatch("result_bits", o_result_bits, pending_results[0]);
                void'(pending_results.pop_front());
            end
        end
    end

    // Watchdog: count cycles with no handshake; fail the run once the count reaches STALL_LIMIT.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (i_rst_n) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        t_row rows[$];
        rows = '{
            '{64'd0,       32'd5,      1'b1, 64'd0},       // exact zero
            '{NEG_ZERO,    32'hFFFF_FFFF, 1'b1, 64'd0},    // negative zero, negative power
            '{64'h3E45_798E_E230_8C3A, EXP_MIN, 1'b1, 64'd0}, // 1e-8 is near zero
            '{{1'b1, NEAR_ZERO_MAG - 63'd1}, EXP_MAX, 1'b1, 64'd0},
            '{TWO,         32'd0,      1'b1, ONE_BITS},
            '{QNAN,        32'd0,      1'b1, ONE_BITS},    // NaN with zero power
            '{MAX_DBL,     32'd0,      1'b1, ONE_BITS},
            '{{1'b0, NEAR_ZERO_MAG}, 32'd3, 1'b0, 64'd0},  // bound itself is not near zero
            '{{1'b1, NEAR_ZERO_MAG}, 32'hFFFF_FFFF, 1'b0, 64'd0},
            '{TWO,         32'd10,     1'b0, 64'd0},
            '{TWO,         EXP_MIN,    1'b0, 64'd0},       // most negative power
            '{NEG_ONE,     EXP_MIN,    1'b0, 64'd0},
            '{NEG_ONE,     EXP_MAX,    1'b0, 64'd0},
            '{HALF,        EXP_MAX,    1'b0, 64'd0},       // underflows to zero
            '{HALF,        32'hFFFF_FC00, 1'b0, 64'd0},
            '{{1'b1, HALF[62:0]}, 32'hFFFF_F7FF, 1'b0, 64'd0}, // reciprocal of negative zero
            '{POS_INF,     32'hFFFF_FFFF, 1'b0, 64'd0},    // reciprocal of infinity
            '{NEG_INF,     32'd3,      1'b0, 64'd0},
            '{NEG_INF,     32'hFFFF_FFFD, 1'b0, 64'd0},
            '{QNAN,        32'd7,      1'b0, 64'd0},
            '{SNAN_NEG,    32'hFFFF_FFF9, 1'b0, 64'd0},
            '{MAX_DBL,     32'd2,      1'b0, 64'd0},
            '{64'h3FF8_0000_0000_0000, 32'd1, 1'b0, 64'd0},
            '{64'hC008_0000_0000_0000, 32'hFFFF_FFFF, 1'b0, 64'd0},
            '{64'h3FF0_0000_0000_0001, 32'h0FFF_FFFF, 1'b0, 64'd0}
        };

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[k]) send_item(rows[k].base, rows[k].expo, rows[k].known, rows[k].result);

        for (int n = 0; n < N_RANDOM; n++) begin
            // alternate stretches with and without idling
            if (n % 150 == 0) quiet_phase = ($urandom_range(3) == 0);
            // hold off once until the block has drained completely
            if (n == N_RANDOM / 2) begin
                while (pending_results.size() != 0) @(posedge i_clk);
            end
            send_item(pick_base(), pick_exponent(), 1'b0, 64'd0);
        end

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
+incdir+hdl
hdl/fpsq_pkg.sv
hdl/fpsq_mul.sv
hdl/fpsq_div.sv
hdl/fpsq_dp.sv
hdl/fpsq_ctrl.sv
hdl/float_power_by_squaring_core.sv
dv/float_power_by_squaring_core_test.sv
